### sv/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// shared constants, operation and status codes, pipeline record types and
// saturation helpers for the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  // default number of fraction bits of the fixed-point operands
  localparam int FRAC_BITS_DEF = 16;

  // quotient and root bits produced by the iterative stages
  localparam int QUO_BITS = 32;

  // operation codes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_NEG  = 3'd4;
  localparam logic [2:0] OP_CONJ = 3'd5;
  localparam logic [2:0] OP_MAG  = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  // one lane of the restoring divider
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
    logic        big;
    logic        neg;
  } div_lane_t;

  // square root lane
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sqrt_lane_t;

  // record carried through the iterative stages
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  status;
    logic [63:0] den;
    div_lane_t   dre;
    div_lane_t   dim;
    sqrt_lane_t  sq;
  } pipe_t;

  // clamp a signed value into 32 bits, msb of result is the saturation flag
  function automatic logic [32:0] sat_s66(input logic signed [65:0] x);
    logic [32:0] r;
    if (x > 66'sh0_7FFF_FFFF)       r = {1'b1, 32'h7FFF_FFFF};
    else if (x < -66'sh0_8000_0000) r = {1'b1, 32'h8000_0000};
    else                            r = {1'b0, x[31:0]};
    return r;
  endfunction

  // clamp a sign and magnitude value, msb of result is the saturation flag
  function automatic logic [32:0] sat_sm(input logic neg, input logic [31:0] mag,
                                          input logic big);
    logic [32:0] r;
    if (!neg) begin
      if (big || mag > 32'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else                            r = {1'b0, mag};
    end else begin
      if (big || mag > 32'h8000_0000) r = {1'b1, 32'h8000_0000};
      else                            r = {1'b0, 32'(0) - mag};
    end
    return r;
  endfunction

endpackage

### sv/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// four register stages: products, cross sums, multiply result and divider
// operand preparation, divider overflow check and lane set-up
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [2:0]         op,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output pipe_t              p_r
);

  localparam int NUM_W = 64 + FRAC_BITS;

  // stage 1 registers
  logic [2:0]         op1_r;
  logic [31:0]        re1_r, im1_r;
  logic               sat1_r;
  logic signed [63:0] rr_r, ii_r, ri_r, ir_r, sq0_r, sq1_r;
  logic [31:0]        re1_nxt, im1_nxt;
  logic               sat1_nxt;
  logic signed [31:0] sx, sy;

  // stage 2 registers
  logic [2:0]         op2_r;
  logic [31:0]        re2_r, im2_r;
  logic               sat2_r;
  logic signed [64:0] sre2_r, sim2_r;
  logic [63:0]        den2_r;

  // stage 3 registers
  logic [2:0]         op3_r;
  logic [31:0]        re3_r, im3_r;
  logic               sat3_r;
  logic               nre3_r, nim3_r;
  logic [63:0]        mre3_r, mim3_r, den3_r;
  logic [32:0]        mre_nxt, mim_nxt;
  logic signed [64:0] shre, shim;

  // stage 4 set-up
  logic [NUM_W-1:0]   nre, nim;
  pipe_t              p_nxt;

  // simple operations resolve here, squares pick operand a for magnitude
  always_comb begin
    logic [32:0] r0, r1;
    r0 = '0;
    r1 = '0;
    case (op)
      OP_ADD: begin
        r0 = sat_s66(66'(a_re) + 66'(b_re));
        r1 = sat_s66(66'(a_im) + 66'(b_im));
      end
      OP_SUB: begin
        r0 = sat_s66(66'(a_re) - 66'(b_re));
        r1 = sat_s66(66'(a_im) - 66'(b_im));
      end
      OP_NEG: begin
        r0 = sat_s66(-66'(a_re));
        r1 = sat_s66(-66'(a_im));
      end
      OP_CONJ: begin
        r0 = sat_s66(66'(a_re));
        r1 = sat_s66(-66'(a_im));
      end
      default: begin
        r0 = '0;
        r1 = '0;
      end
    endcase
    re1_nxt  = r0[31:0];
    im1_nxt  = r1[31:0];
    sat1_nxt = r0[32] | r1[32];
  end

  assign sx = (op == OP_MAG) ? a_re : b_re;
  assign sy = (op == OP_MAG) ? a_im : b_im;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= op;
      re1_r  <= re1_nxt;
      im1_r  <= im1_nxt;
      sat1_r <= sat1_nxt;
      rr_r   <= a_re * b_re;
      ii_r   <= a_im * b_im;
      ri_r   <= a_re * b_im;
      ir_r   <= a_im * b_re;
      sq0_r  <= sx * sx;
      sq1_r  <= sy * sy;
    end
  end

  // stage 2: cross sums and squared norm
  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      re2_r  <= re1_r;
      im2_r  <= im1_r;
      sat2_r <= sat1_r;
      sre2_r <= (op1_r == OP_MUL) ? 65'(rr_r) - 65'(ii_r) : 65'(rr_r) + 65'(ii_r);
      sim2_r <= (op1_r == OP_MUL) ? 65'(ir_r) + 65'(ri_r) : 65'(ir_r) - 65'(ri_r);
      den2_r <= 64'(sq0_r) + 64'(sq1_r);
    end
  end

  // stage 3: multiply result by floor shift, sign and magnitude for divide
  assign shre    = sre2_r >>> FRAC_BITS;
  assign shim    = sim2_r >>> FRAC_BITS;
  assign mre_nxt = sat_s66(66'(shre));
  assign mim_nxt = sat_s66(66'(shim));

  always_ff @(posedge clk) begin
    if (en) begin
      op3_r  <= op2_r;
      if (op2_r == OP_MUL) begin
        re3_r  <= mre_nxt[31:0];
        im3_r  <= mim_nxt[31:0];
        sat3_r <= mre_nxt[32] | mim_nxt[32];
      end else begin
        re3_r  <= re2_r;
        im3_r  <= im2_r;
        sat3_r <= sat2_r;
      end
      nre3_r <= sre2_r[64];
      nim3_r <= sim2_r[64];
      mre3_r <= sre2_r[64] ? 64'(-sre2_r) : 64'(sre2_r);
      mim3_r <= sim2_r[64] ? 64'(-sim2_r) : 64'(sim2_r);
      den3_r <= den2_r;
    end
  end

  // stage 4: scaled numerators, overflow check on the upper part
  assign nre = NUM_W'(mre3_r) << FRAC_BITS;
  assign nim = NUM_W'(mim3_r) << FRAC_BITS;

  always_comb begin
    p_nxt         = '0;
    p_nxt.op      = op3_r;
    p_nxt.re      = re3_r;
    p_nxt.im      = im3_r;
    p_nxt.status  = sat3_r ? ST_SAT : ST_OK;
    p_nxt.den     = den3_r;
    if (op3_r == OP_DIV && den3_r == '0) p_nxt.status = ST_DIV0;
    p_nxt.dre.neg = nre3_r;
    p_nxt.dre.big = 64'(nre[NUM_W-1:QUO_BITS]) >= den3_r;
    p_nxt.dre.rem = 64'(nre[NUM_W-1:QUO_BITS]);
    p_nxt.dre.num = nre[QUO_BITS-1:0];
    p_nxt.dim.neg = nim3_r;
    p_nxt.dim.big = 64'(nim[NUM_W-1:QUO_BITS]) >= den3_r;
    p_nxt.dim.rem = 64'(nim[NUM_W-1:QUO_BITS]);
    p_nxt.dim.num = nim[QUO_BITS-1:0];
    p_nxt.sq.rem  = den3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

### sv/cau_step.sv
// ----------------------------------------------------------------------------
// cau_step
// one registered iteration: a restoring divide step on both quotient lanes
// and one digit of the integer square root
// ----------------------------------------------------------------------------
module cau_step import cau_pkg::*; #(
  parameter int BIT = 31
) (
  input  logic  clk,
  input  logic  en,
  input  pipe_t d,
  output pipe_t q_r
);

  pipe_t q_nxt;

  function automatic div_lane_t div_step(input div_lane_t l, input logic [63:0] den);
    div_lane_t   o;
    logic [64:0] t;
    o = l;
    t = {l.rem, l.num[BIT]};
    if (t >= 65'(den)) begin
      o.rem      = 64'(t - 65'(den));
      o.quo[BIT] = 1'b1;
    end else begin
      o.rem      = t[63:0];
    end
    return o;
  endfunction

  // divide lanes and root digit side by side
  always_comb begin
    logic [65:0] trial;
    q_nxt     = d;
    q_nxt.dre = div_step(d.dre, d.den);
    q_nxt.dim = div_step(d.dim, d.den);
    trial     = (66'(d.sq.root) << (BIT + 1)) + (66'(1) << (2 * BIT));
    if (66'(d.sq.rem) >= trial) begin
      q_nxt.sq.rem       = 64'(66'(d.sq.rem) - trial);
      q_nxt.sq.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

### sv/complex_arithmetic_unit_core.sv
// stages: 4 front stages, 32 digit stages shared by the divider and square
//   root, then one output register
// throughput: one transfer per cycle; the whole pipeline holds while the
//   output register is full and out_tready is low
// reset: synchronous active-low rst_n clears all valid bits
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// pipelined complex ALU on signed fixed-point operands: add, subtract,
// multiply, divide, negate, conjugate and magnitude
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[2:0], a_re[34:3], a_im[66:35], b_re[98:67], b_im[130:99], zero fill
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // res_re[31:0], res_im[63:32], status[65:64], zero fill
  output logic [71:0]  out_tdata
);

  localparam int FRONT = 4;
  localparam int VN    = FRONT + QUO_BITS;

  logic          en;
  logic [VN-1:0] v_r;
  pipe_t         stg [0:QUO_BITS];
  pipe_t         last;
  logic          out_valid_r;
  logic [31:0]   re_r, im_r;
  logic [1:0]    st_r;
  logic [31:0]   re_nxt, im_nxt;
  logic [1:0]    st_nxt;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk  (clk),
    .en   (en),
    .op   (in_tdata[2:0]),
    .a_re (in_tdata[34:3]),
    .a_im (in_tdata[66:35]),
    .b_re (in_tdata[98:67]),
    .b_im (in_tdata[130:99]),
    .p_r  (stg[0])
  );

  // digit stages, most significant first
  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    cau_step #(.BIT(QUO_BITS - 1 - k)) u_step (
      .clk (clk),
      .en  (en),
      .d   (stg[k]),
      .q_r (stg[k+1])
    );
  end

  assign last = stg[QUO_BITS];

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[VN-2:0], in_tvalid};
      out_valid_r <= v_r[VN-1];
    end
  end

  // pick the result for the operation
  always_comb begin
    logic [32:0] r0, r1;
    r0     = '0;
    r1     = '0;
    re_nxt = last.re;
    im_nxt = last.im;
    st_nxt = last.status;
    case (last.op)
      OP_DIV: begin
        if (last.status == ST_DIV0) begin
          re_nxt = '0;
          im_nxt = '0;
        end else begin
          r0     = sat_sm(last.dre.neg, last.dre.quo, last.dre.big);
          r1     = sat_sm(last.dim.neg, last.dim.quo, last.dim.big);
          re_nxt = r0[31:0];
          im_nxt = r1[31:0];
          st_nxt = (r0[32] | r1[32]) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        r0     = sat_sm(1'b0, last.sq.root, 1'b0);
        re_nxt = r0[31:0];
        im_nxt = '0;
        st_nxt = r0[32] ? ST_SAT : ST_OK;
      end
      default: begin
        re_nxt = last.re;
        im_nxt = last.im;
        st_nxt = last.status;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, st_r, im_r, re_r};

endmodule

### sv/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// port-level checks on the complex arithmetic unit, bound to the top level
// ----------------------------------------------------------------------------
module cau_checker import cau_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [135:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [71:0]  out_tdata
);

  // a held result keeps its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // pipeline empty after reset
  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result present after reset");

  // input side open whenever the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // division by zero returns zero
  a_div0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65:64] == ST_DIV0 |-> out_tdata[63:0] == 64'd0)
    else $error("division by zero with nonzero result");

  // no unused status code
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65:64] != 2'd3)
    else $error("invalid status code");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
